[hw/rtl/caseless_substring_locator_macros.svh]
// assertion macros for the caseless substring locator checker
// no dependencies; included by the checker file
`ifndef CASELESS_SUBSTRING_LOCATOR_MACROS_SVH
`define CASELESS_SUBSTRING_LOCATOR_MACROS_SVH

// same-cycle implication under an active-low reset
`define CSL_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("csl assertion failed");

// next-cycle implication under an active-low reset
`define CSL_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("csl assertion failed");

`endif

[hw/rtl/csl_pkg.sv]
// shared constants, register indexes and the case fold function
// no dependencies; used by the matcher, the top level and the testbench
package csl_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int CHAR_COUNT = 16;

	localparam logic [7:0] NEWLINE = 8'h0A;
	localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
	localparam logic [15:0] COL_MAX = 16'hFFFF;
	localparam logic signed [16:0] COL_NEWLINE = -17'sd1;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_CHARS_LOW = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_CHARS_HIGH = 2'd2;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

[hw/rtl/csl_matcher.sv]
// window compare: aligns the folded pattern to the length and checks the byte window
// depends on csl_pkg
module csl_matcher #(
	parameter int PATTERN_MAX = csl_pkg::PATTERN_MAX_DEF
) (
	input  logic [4:0]                                      len,
	input  logic [8*csl_pkg::CHAR_COUNT-1:0]                chars,
	input  logic [PATTERN_MAX-1:0][7:0]                     win,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]                seen,
	output logic                                            hit,
	output logic [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] start
);

	localparam int SW = $clog2(PATTERN_MAX + 1);
	localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [SW-1:0] len_eff;
	logic [SW-1:0] sh;
	logic [PATTERN_MAX-1:0][7:0] rev;
	logic [PATTERN_MAX-1:0][7:0] aligned;
	logic all_eq;

	always_comb begin
		if (int'(len) > PATTERN_MAX) begin
			len_eff = SW'(PATTERN_MAX);
		end else begin
			len_eff = SW'(len);
		end
	end

	// reversed, folded pattern; characters past the register pair read as zero
	for (genvar m = 0; m < PATTERN_MAX; m++) begin : g_rev
		localparam int K = PATTERN_MAX - 1 - m;
		if (K < csl_pkg::CHAR_COUNT) begin : g_chr
			assign rev[m] = csl_pkg::fold_case(chars[8*K +: 8]);
		end else begin : g_zero
			assign rev[m] = 8'h00;
		end
	end

	assign sh = SW'(PATTERN_MAX) - len_eff;
	assign aligned = rev >> {sh, 3'b000};

	always_comb begin
		all_eq = 1'b1;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			if (SW'(j) < len_eff && csl_pkg::fold_case(win[j]) != aligned[j]) begin
				all_eq = 1'b0;
			end
		end
		hit = (len_eff != '0) && (seen >= len_eff) && all_eq;
	end

	assign start = IW'(len_eff - SW'(1));

endmodule

[hw/rtl/caseless_substring_locator.sv]
// top level of the caseless substring locator: config registers, text state, result register
// depends on csl_pkg and csl_matcher
//
//  channel | signals                                  | direction
//  in      | in_valid, in_ready, text_byte, last_byte | request in
//  out     | out_valid, out_ready, found, line/column | request out
//  cfg     | cfg_wr_en, cfg_index, cfg_data           | write only
//
// one byte per cycle while in_ready is high; a result is registered after its byte is accepted
// the byte passes an input register, then the window shift and compare load the result register
// in_ready drops only while a result waits on out_ready and the input stage is full
// reset clears config, counters and handshake state; the byte window needs no clear
module caseless_substring_locator #(
	parameter int PATTERN_MAX = csl_pkg::PATTERN_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [csl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      text_byte,
	input  logic                            last_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [23:0]                     line_index,
	output logic signed [16:0]              column_index
);

	localparam int SW = $clog2(PATTERN_MAX + 1);
	localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [4:0]  len_q;
	logic [63:0] chars_lo_q;
	logic [63:0] chars_hi_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	logic [23:0]   line_q;
	logic [15:0]   col_q;
	logic [SW-1:0] seen_q;
	logic          reported_q;
	logic [PATTERN_MAX-1:0][7:0]  win_q;
	logic [PATTERN_MAX-1:0][23:0] wline_q;
	logic [PATTERN_MAX-1:0][16:0] wcol_q;

	logic [23:0]   line_nxt;
	logic [15:0]   col_nxt;
	logic [SW-1:0] seen_nxt;
	logic [PATTERN_MAX-1:0][7:0]  win_nxt;
	logic [PATTERN_MAX-1:0][23:0] wline_nxt;
	logic [PATTERN_MAX-1:0][16:0] wcol_nxt;

	logic          hit;
	logic [IW-1:0] start;
	logic          result_load;

	logic               out_valid_q;
	logic               found_q;
	logic [23:0]        line_out_q;
	logic signed [16:0] col_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			chars_lo_q <= '0;
			chars_hi_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				csl_pkg::CFG_PATTERN_LENGTH:     len_q      <= cfg_data[4:0];
				csl_pkg::CFG_PATTERN_CHARS_LOW:  chars_lo_q <= cfg_data;
				csl_pkg::CFG_PATTERN_CHARS_HIGH: chars_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	// position of the incoming byte and the shifted window
	always_comb begin
		if (byte_s1 == csl_pkg::NEWLINE) begin
			line_nxt = (line_q != csl_pkg::LINE_MAX) ? line_q + 24'd1 : line_q;
			col_nxt  = '0;
			wline_nxt[0] = line_nxt;
			wcol_nxt[0]  = csl_pkg::COL_NEWLINE;
		end else begin
			line_nxt = line_q;
			col_nxt  = (col_q != csl_pkg::COL_MAX) ? col_q + 16'd1 : col_q;
			wline_nxt[0] = line_q;
			wcol_nxt[0]  = {1'b0, col_q};
		end
		win_nxt[0] = byte_s1;
		for (int j = 1; j < PATTERN_MAX; j++) begin
			win_nxt[j]   = win_q[j-1];
			wline_nxt[j] = wline_q[j-1];
			wcol_nxt[j]  = wcol_q[j-1];
		end
		seen_nxt = (seen_q != SW'(PATTERN_MAX)) ? seen_q + SW'(1) : seen_q;
	end

	csl_matcher #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_matcher (
		.len   (len_q),
		.chars ({chars_hi_q, chars_lo_q}),
		.win   (win_nxt),
		.seen  (seen_nxt),
		.hit   (hit),
		.start (start)
	);

	assign result_load = advance && !reported_q && (hit || last_s1);

	// text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q     <= '0;
			col_q      <= '0;
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				line_q     <= '0;
				col_q      <= '0;
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else begin
				line_q     <= line_nxt;
				col_q      <= col_nxt;
				seen_q     <= seen_nxt;
				reported_q <= reported_q || hit;
			end
		end
	end

	// window contents are only read below the fill count
	always_ff @(posedge clk) begin
		if (advance) begin
			win_q   <= win_nxt;
			wline_q <= wline_nxt;
			wcol_q  <= wcol_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			found_q <= hit;
			if (hit) begin
				line_out_q <= wline_nxt[start];
				col_out_q  <= wcol_nxt[start];
			end else begin
				line_out_q <= '0;
				col_out_q  <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign line_index   = line_out_q;
	assign column_index = col_out_q;

endmodule

[hw/rtl/csl_checker.sv]
// port-level checks for the caseless substring locator, bound to the top level
// depends on caseless_substring_locator_macros.svh
`include "caseless_substring_locator_macros.svh"

module csl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               found,
	input logic [23:0]        line_index,
	input logic signed [16:0] column_index
);

	`CSL_ASSERT_IMP(a_stall_source, clk, arst_n, !in_ready, out_valid && !out_ready)
	`CSL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(line_index) && $stable(column_index))
	`CSL_ASSERT_IMP(a_miss_zero, clk, arst_n, out_valid && !found, line_index == 24'd0 && column_index == 17'sd0)
	`CSL_ASSERT_IMP(a_newline_line, clk, arst_n, out_valid && found && column_index == -17'sd1, line_index != 24'd0)

endmodule

bind caseless_substring_locator csl_checker u_csl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.found        (found),
	.line_index   (line_index),
	.column_index (column_index)
);

[tb/sv/caseless_substring_locator_test.sv]
// self-checking testbench for caseless_substring_locator: directed and random texts
// with a byte-level predictor of match position and line/column tracking
// depends on csl_pkg and the caseless_substring_locator rtl
module caseless_substring_locator_test;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_ITEMS = 600;
	localparam logic [csl_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} text_req_t;

	typedef struct packed {
		logic               found;
		logic [23:0]        line;
		logic signed [16:0] col;
	} locate_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [csl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] text_byte = '0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic [23:0] line_index;
	logic signed [16:0] column_index;

	caseless_substring_locator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.text_byte(text_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.line_index(line_index),
		.column_index(column_index)
	);

	text_req_t text_q[$];
	locate_result_t hits_q[$];
	text_req_t next_req;
	int err_cnt = 0;
	int sent_cnt = 0;
	int cycle_cnt = 0;
	int send_gap = 0;
	int rx_stall = 0;
	int hold_ticket = 0;
	int hold_served = 0;
	bit no_idle = 1'b0;
	logic in_fire_q = 1'b0;

	// predictor copy of config and text state
	logic [4:0] pat_len_r = '0;
	logic [63:0] pat_lo_r = '0;
	logic [63:0] pat_hi_r = '0;
	logic [7:0] win_byte [csl_pkg::PATTERN_MAX_DEF];
	logic [23:0] win_line [csl_pkg::PATTERN_MAX_DEF];
	logic signed [16:0] win_col [csl_pkg::PATTERN_MAX_DEF];
	int seen_cnt;
	logic [23:0] line_cnt;
	logic [15:0] col_cnt;
	bit reported;
	logic [7:0] pat_buf [csl_pkg::PATTERN_MAX_DEF];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
	endfunction

	function automatic logic [7:0] pat_char(int k);
		if (k < 8) begin
			return pat_lo_r[8*k +: 8];
		end else if (k < 16) begin
			return pat_hi_r[8*(k-8) +: 8];
		end
		return 8'h00;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 40) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_char();
		int r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			c = 8'h61 + 8'($urandom_range(0, 3));
			if ($urandom_range(0, 1) == 1) begin
				c = c ^ 8'h20;
			end
		end else if (r < 62) begin
			c = csl_pkg::NEWLINE;
		end else if (r < 70) begin
			c = 8'h00;
		end else if (r < 80) begin
			case ($urandom_range(0, 5))
				0: c = 8'h40;
				1: c = 8'h5B;
				2: c = 8'h60;
				3: c = 8'h7B;
				4: c = 8'hC1;
				default: c = 8'hE1;
			endcase
		end else begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	function automatic logic [7:0] flip_case(logic [7:0] c);
		if (to_lower(c) >= 8'h61 && to_lower(c) <= 8'h7A && $urandom_range(0, 1) == 1) begin
			return c ^ 8'h20;
		end
		return c;
	endfunction

	task automatic clear_window();
		for (int i = 0; i < csl_pkg::PATTERN_MAX_DEF; i++) begin
			win_byte[i] = '0;
			win_line[i] = '0;
			win_col[i] = '0;
		end
		seen_cnt = 0;
		line_cnt = '0;
		col_cnt = '0;
		reported = 1'b0;
	endtask

	task automatic track_byte(input logic [7:0] b, input logic last);
		logic [23:0] at_line;
		logic signed [16:0] at_col;
		int len;
		bit hit;
		if (b == csl_pkg::NEWLINE) begin
			if (line_cnt != csl_pkg::LINE_MAX) begin
				line_cnt = line_cnt + 24'd1;
			end
			at_line = line_cnt;
			at_col = csl_pkg::COL_NEWLINE;
			col_cnt = '0;
		end else begin
			at_line = line_cnt;
			at_col = $signed({1'b0, col_cnt});
			if (col_cnt != csl_pkg::COL_MAX) begin
				col_cnt = col_cnt + 16'd1;
			end
		end
		for (int i = csl_pkg::PATTERN_MAX_DEF - 1; i > 0; i--) begin
			win_byte[i] = win_byte[i-1];
			win_line[i] = win_line[i-1];
			win_col[i] = win_col[i-1];
		end
		win_byte[0] = b;
		win_line[0] = at_line;
		win_col[0] = at_col;
		if (seen_cnt < csl_pkg::PATTERN_MAX_DEF) begin
			seen_cnt++;
		end
		len = (pat_len_r > csl_pkg::PATTERN_MAX_DEF) ? csl_pkg::PATTERN_MAX_DEF
			: int'(pat_len_r);
		if (!reported && len > 0 && seen_cnt >= len) begin
			hit = 1'b1;
			for (int k = 0; k < len; k++) begin
				if (to_lower(pat_char(k)) != to_lower(win_byte[len-1-k])) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				hits_q.push_back('{1'b1, win_line[len-1], win_col[len-1]});
				reported = 1'b1;
			end
		end
		if (last) begin
			if (!reported) begin
				hits_q.push_back('{1'b0, 24'd0, 17'sd0});
			end
			clear_window();
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (!(in_valid && !in_fire_q)) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (text_q.size() != 0) begin
				next_req = text_q.pop_front();
				in_valid <= 1'b1;
				text_byte <= next_req.data;
				last_byte <= next_req.last;
				send_gap <= gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (hold_ticket != hold_served) begin
			hold_served <= hold_ticket;
			rx_stall <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < 25) begin
				rx_stall <= gap_len();
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		locate_result_t want;
		if (arst_n) begin
			in_fire_q <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				track_byte(text_byte, last_byte);
			end
			if (out_valid && out_ready) begin
				if (hits_q.size() == 0) begin
					$display("%0t: unexpected result found=%0d line=%0d col=%0d",
						$time, found, line_index, column_index);
					err_cnt++;
				end else begin
					want = hits_q.pop_front();
					if (found !== want.found) begin
						$display("%0t: found expected %0d actual %0d", $time, want.found, found);
						err_cnt++;
					end
					if (line_index !== want.line) begin
						$display("%0t: line_index expected %0d actual %0d",
							$time, want.line, line_index);
						err_cnt++;
					end
					if (column_index !== want.col) begin
						$display("%0t: column_index expected %0d actual %0d",
							$time, want.col, column_index);
						err_cnt++;
					end
				end
			end
		end else begin
			in_fire_q <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_one(input logic [7:0] b, input logic last);
		text_q.push_back('{b, last});
		sent_cnt++;
	endtask

	task automatic send_str(input string s, input bit close);
		for (int i = 0; i < s.len(); i++) begin
			send_one(s[i], close && (i == s.len() - 1));
		end
	endtask

	// sampled at the rising edge, after the driver has settled
	task automatic wait_drained();
		@(posedge clk);
		while (text_q.size() != 0 || in_valid || hits_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [csl_pkg::CFG_INDEX_W-1:0] idx,
		input logic [63:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			csl_pkg::CFG_PATTERN_LENGTH: pat_len_r = data[4:0];
			csl_pkg::CFG_PATTERN_CHARS_LOW: pat_lo_r = data;
			csl_pkg::CFG_PATTERN_CHARS_HIGH: pat_hi_r = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic load_pattern(input logic [63:0] len_word);
		logic [63:0] lo;
		logic [63:0] hi;
		for (int k = 0; k < 8; k++) begin
			lo[8*k +: 8] = pat_buf[k];
			hi[8*k +: 8] = pat_buf[k+8];
		end
		wait_drained();
		write_reg(csl_pkg::CFG_PATTERN_LENGTH, len_word);
		write_reg(csl_pkg::CFG_PATTERN_CHARS_LOW, lo);
		write_reg(csl_pkg::CFG_PATTERN_CHARS_HIGH, hi);
	endtask

	task automatic load_pattern_str(input string s, input int len_val);
		for (int k = 0; k < csl_pkg::PATTERN_MAX_DEF; k++) begin
			pat_buf[k] = (k < s.len()) ? s[k] : 8'h00;
		end
		load_pattern(64'(len_val));
	endtask

	task automatic random_phase();
		int r;
		int plen;
		int used;
		int ntext;
		int tlen;
		int pos;
		int cut;
		bit shaped;
		bit close;
		logic [63:0] len_word;
		logic [7:0] txt[$];
		r = $urandom_range(0, 99);
		if (r < 5) begin
			plen = 0;
		end else if (r < 70) begin
			plen = $urandom_range(1, 4);
		end else if (r < 92) begin
			plen = $urandom_range(5, 16);
		end else begin
			plen = $urandom_range(17, 31);
		end
		used = (plen > csl_pkg::PATTERN_MAX_DEF) ? csl_pkg::PATTERN_MAX_DEF : plen;
		for (int k = 0; k < csl_pkg::PATTERN_MAX_DEF; k++) begin
			pat_buf[k] = (k < used) ? pick_char() : 8'($urandom_range(0, 255));
		end
		len_word = 64'(plen);
		if ($urandom_range(0, 4) == 0) begin
			len_word = {$urandom, $urandom};
			len_word[4:0] = 5'(plen);
		end
		load_pattern(len_word);
		no_idle = ($urandom_range(0, 9) == 0);
		ntext = $urandom_range(1, 5);
		for (int t = 0; t < ntext; t++) begin
			txt.delete();
			tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 20);
			for (int i = 0; i < tlen; i++) begin
				txt.push_back(pick_char());
			end
			shaped = ($urandom_range(0, 99) < 80) && used > 0;
			if (shaped) begin
				pos = $urandom_range(0, tlen);
				cut = ($urandom_range(0, 9) == 0) ? used - 1 : used;
				for (int k = cut - 1; k >= 0; k--) begin
					txt.insert(pos, flip_case(pat_buf[k]));
				end
			end
			close = !(t == ntext - 1 && $urandom_range(0, 9) == 0);
			for (int i = 0; i < txt.size(); i++) begin
				send_one(txt[i], close && (i == txt.size() - 1));
			end
		end
	endtask

	initial begin
		clear_window();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero length never matches
		send_str("ab", 1'b1);
		load_pattern_str("Ab", 2);
		send_str("xaB", 1'b1);
		// match starting on a newline
		load_pattern_str("\nX", 2);
		send_str("q\nx", 1'b1);
		// zero bytes in pattern and text, short window
		load_pattern_str("", 2);
		send_one(8'h00, 1'b1);
		send_one(8'h00, 1'b0);
		send_one(8'h00, 1'b1);
		// no folding outside letters
		load_pattern_str("@[", 2);
		send_str("`{", 1'b1);
		// match on last byte, then silence until text end
		load_pattern_str("z", 1);
		send_str("z", 1'b1);
		send_str("zZz", 1'b1);
		wait_drained();
		write_reg(CFG_SPARE, {$urandom, $urandom});
		// length above maximum
		load_pattern_str("abcdefghijklmnop", 31);
		send_str("ABCDEFGHIJKLMNOP", 1'b1);

		sent_cnt = 0;
		while (sent_cnt < RANDOM_ITEMS) begin
			random_phase();
		end
		no_idle = 1'b0;

		// receiver holds off while one-byte texts keep coming
		load_pattern_str("a", 1);
		no_idle = 1'b1;
		hold_ticket++;
		for (int i = 0; i < 40; i++) begin
			send_one(($urandom_range(0, 1) == 1) ? 8'h41 : 8'h62, 1'b1);
		end
		wait_drained();
		no_idle = 1'b0;

		load_pattern_str("b\n", 2);
		send_str("a\nab\nb", 1'b1);
		wait_drained();
		repeat (8) @(negedge clk);
		if (err_cnt == 0 && hits_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/csl_pkg.sv
hw/rtl/csl_matcher.sv
hw/rtl/caseless_substring_locator.sv
hw/rtl/csl_checker.sv
tb/sv/caseless_substring_locator_test.sv
